/* rtl/clsrng_pkg.sv */
package clsrng_pkg;

    // Field widths
    localparam int RAW_W  = 31;
    localparam int IDX_W  = 16;
    localparam int PROD_W = 47;

    typedef logic [RAW_W-1:0]  t_word;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [PROD_W-1:0] t_prod;

    // Generator constants
    localparam int unsigned TABLE_DEPTH_DEF = 32;
    localparam t_word       MOD_ONE    = 31'd2147483563;
    localparam t_word       MOD_TWO    = 31'd2147483399;
    localparam t_word       OUT_TOP    = 31'd2147483562;
    localparam t_idx        MUL_ONE    = 16'd40014;
    localparam t_idx        MUL_TWO    = 16'd40692;
    // 2^31 minus each modulus, used to fold the high part back in
    localparam logic [7:0]  FOLD_ONE   = 8'd85;
    localparam logic [7:0]  FOLD_TWO   = 8'd249;
    localparam t_word       G2_RESET   = 31'd123456789;
    localparam t_word       SEED_RESET = 31'd1;

    // Quotient carry and remainder of a product reduced by 2^31 - c
    typedef struct packed {
        logic  carry;
        t_word rem;
    } t_fold;

    // Reduce p modulo m = 2^31 - c: p = hi*m + (hi*c + lo), and hi*c + lo < 2m,
    // so one compare and subtract finishes it; the quotient is hi + carry.
    function automatic t_fold fold_mod(input t_prod p, input logic [7:0] c, input t_word m);
        logic [31:0] t;
        t_fold       r;
        t = 32'(p[PROD_W-1:RAW_W]) * 32'(c) + 32'(p[RAW_W-1:0]);
        if (t >= 32'(m)) begin
            r.carry = 1'b1;
            r.rem   = t_word'(t - 32'(m));
        end else begin
            r.carry = 1'b0;
            r.rem   = t_word'(t);
        end
        return r;
    endfunction

endpackage

/* rtl/clsrng_if.sv */
// Request channel: one word per draw
interface clsrng_req_if import clsrng_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  kind;
    t_idx  range_n;

    modport source (output valid, output kind, output range_n, input ready);
    modport sink   (input valid, input kind, input range_n, output ready);
endinterface

// Response channel: one word per draw
interface clsrng_rsp_if import clsrng_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word raw_value;
    t_idx  index_value;

    modport source (output valid, output raw_value, output index_value, input ready);
    modport sink   (input valid, input raw_value, input index_value, output ready);
endinterface

// Seed register write channel
interface clsrng_cfg_if import clsrng_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word seed_value;

    modport source (output valid, output seed_value, input ready);
    modport sink   (input valid, input seed_value, output ready);
endinterface

/* rtl/clsrng_ram.sv */
module clsrng_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/combined_lcg_shuffle_rng_core.sv */
// Draw: ST_RD to ST_OUT, which waits for a free response register; one draw at a time,
//   set by the shared 31x16 multiplier and fold unit walking the read-modify-write.
// Restart (kind 1, or first draw after reset): ST_SEED and ST_WMUL/ST_WRED warm-up
//   steps of the first generator, then ST_WQ and ST_WSLOT.
// Reset: seed 1, generators and last output to their initial values, not started;
//   the shuffle table holds garbage until the first restart fills it.
module combined_lcg_shuffle_rng_core import clsrng_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    clsrng_req_if.sink   i_req,
    clsrng_rsp_if.source o_rsp,
    clsrng_cfg_if.sink   i_cfg
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 8);
    localparam int RW = $clog2(TABLE_DEPTH) + 2;
    localparam int QW = RAW_W + RW;
    localparam logic [63:0] SLOT_DIV = 64'd1 + 64'(OUT_TOP) / 64'(TABLE_DEPTH);
    localparam logic [63:0] SLOT_REC = (64'd1 << RAW_W) / SLOT_DIV;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_WMUL,
        ST_WRED,
        ST_WQ,
        ST_WSLOT,
        ST_RD,
        ST_G1,
        ST_G2,
        ST_Y,
        ST_IDX,
        ST_OUT
    } t_state;

    t_state          r_state;
    t_word           r_seed;
    t_word           r_g1;
    t_word           r_g2;
    t_word           r_last;
    t_word           r_tbl;
    logic            r_started;
    logic [AW-1:0]   r_slot;
    logic [AW-1:0]   r_q0;
    logic [CW-1:0]   r_cnt;
    t_idx            r_n;
    t_prod           r_prod;
    logic            r_out_valid;
    t_word           r_out_raw;
    t_idx            r_out_idx;

    t_word           mul_a;
    t_idx            mul_b;
    t_prod           n_prod;
    t_fold           fold1;
    t_fold           fold2;
    t_word           n_seed;
    logic signed [32:0] y_diff;
    logic signed [32:0] y_wrap;
    t_word           n_last;
    logic [QW-1:0]   q_prod;
    logic [AW-1:0]   n_q0;
    logic [AW:0]     q_inc;
    logic [32:0]     q_thr;
    logic [AW:0]     slot_w;
    logic [AW-1:0]   n_slot;
    t_idx            n_idx;
    logic            warm_wr;
    logic            out_load;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    t_word           ram_wdata;
    logic            ram_re;
    t_word           ram_rdata;

    // Select operands of the shared multiplier
    always_comb begin
        case (r_state)
            ST_G1: begin
                mul_a = r_g2;
                mul_b = MUL_TWO;
            end
            ST_IDX: begin
                mul_a = r_last;
                mul_b = r_n;
            end
            default: begin
                mul_a = r_g1;
                mul_b = MUL_ONE;
            end
        endcase
    end

    assign n_prod = t_prod'(PROD_W'(mul_a) * PROD_W'(mul_b));
    assign fold1  = fold_mod(r_prod, FOLD_ONE, MOD_ONE);
    assign fold2  = fold_mod(r_prod, FOLD_TWO, MOD_TWO);
    assign n_idx  = t_idx'(17'(r_prod[PROD_W-1:RAW_W]) + 17'(fold1.carry));

    // Reduce the seed below the first modulus, zero taken as one
    always_comb begin
        n_seed = r_seed;
        if (n_seed >= MOD_ONE) begin
            n_seed = n_seed - MOD_ONE;
        end
        if (n_seed == '0) begin
            n_seed = SEED_RESET;
        end
    end

    // Table entry minus second generator, wrapped into 1..OUT_TOP
    always_comb begin
        y_diff = $signed({2'b00, r_tbl}) - $signed({2'b00, r_g2});
        y_wrap = y_diff;
        if (y_diff < 33'sd1) begin
            y_wrap = y_diff + $signed({2'b00, OUT_TOP});
        end
        if (y_wrap < 33'sd1) begin
            n_last = 31'd1;
        end else if (y_wrap > $signed({2'b00, OUT_TOP})) begin
            n_last = OUT_TOP;
        end else begin
            n_last = t_word'(y_wrap);
        end
    end

    // Slot estimate by reciprocal, at most one below the true quotient
    assign q_prod = QW'(r_last) * QW'(SLOT_REC);
    assign n_q0   = q_prod[RAW_W +: AW];

    // Correct the estimate and clamp to the last slot
    always_comb begin
        q_inc  = {1'b0, r_q0} + 1'b1;
        q_thr  = 33'(q_inc) * 33'(SLOT_DIV);
        slot_w = (33'(r_last) >= q_thr) ? q_inc : {1'b0, r_q0};
        if (slot_w >= (AW+1)'(TABLE_DEPTH)) begin
            n_slot = AW'(TABLE_DEPTH - 1);
        end else begin
            n_slot = slot_w[AW-1:0];
        end
    end

    // Table port: warm-up fill, draw read, draw refill
    assign warm_wr   = (r_state == ST_WRED) && (r_cnt < CW'(TABLE_DEPTH));
    assign ram_we    = warm_wr || (r_state == ST_G2);
    assign ram_waddr = (r_state == ST_WRED) ? r_cnt[AW-1:0] : r_slot;
    assign ram_wdata = (r_state == ST_WRED) ? fold1.rem : r_g1;
    assign ram_re    = (r_state == ST_RD);

    // Load the response register once it is free or being taken
    assign out_load  = (r_state == ST_OUT) && (!r_out_valid || o_rsp.ready);

    clsrng_ram #(
        .WIDTH (RAW_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    // Sequencer, generator state and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seed      <= SEED_RESET;
            r_g1        <= '0;
            r_g2        <= G2_RESET;
            r_last      <= '0;
            r_started   <= 1'b0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_seed <= i_cfg.seed_value;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_n     <= i_req.range_n;
                        r_state <= (i_req.kind || !r_started) ? ST_SEED : ST_RD;
                    end
                end
                ST_SEED: begin
                    r_g1    <= n_seed;
                    r_g2    <= n_seed;
                    r_cnt   <= CW'(TABLE_DEPTH + 7);
                    r_state <= ST_WMUL;
                end
                ST_WMUL: begin
                    r_prod  <= n_prod;
                    r_state <= ST_WRED;
                end
                ST_WRED: begin
                    r_g1 <= fold1.rem;
                    if (r_cnt == '0) begin
                        r_last    <= fold1.rem;
                        r_started <= 1'b1;
                        r_state   <= ST_WQ;
                    end else begin
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= ST_WMUL;
                    end
                end
                ST_WQ: begin
                    r_q0    <= n_q0;
                    r_state <= ST_WSLOT;
                end
                ST_WSLOT: begin
                    r_slot  <= n_slot;
                    r_state <= ST_RD;
                end
                ST_RD: begin
                    r_prod  <= n_prod;
                    r_state <= ST_G1;
                end
                ST_G1: begin
                    r_g1    <= fold1.rem;
                    r_tbl   <= ram_rdata;
                    r_prod  <= n_prod;
                    r_state <= ST_G2;
                end
                ST_G2: begin
                    r_g2    <= fold2.rem;
                    r_state <= ST_Y;
                end
                ST_Y: begin
                    r_last  <= n_last;
                    r_state <= ST_IDX;
                end
                ST_IDX: begin
                    r_prod  <= n_prod;
                    r_q0    <= n_q0;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    // hold until the response register is free
                    if (out_load) begin
                        r_out_raw   <= r_last;
                        r_out_idx   <= n_idx;
                        r_slot      <= n_slot;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready       = (r_state == ST_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.raw_value   = r_out_raw;
    assign o_rsp.index_value = r_out_idx;

    // A draw never starts on an unfilled table
    a_draw_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> r_started)
        else $error("draw started before table fill");

    // First generator stays inside its modulus when a draw begins
    a_g1_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> (r_g1 != '0) && (r_g1 < MOD_ONE))
        else $error("first generator out of range");

    // Response word stays within 1..OUT_TOP
    a_raw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_raw != '0) && (r_out_raw <= OUT_TOP))
        else $error("raw value out of range");

    // Refill goes back to the slot that was read
    a_refill_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_G2) |-> ram_we && (ram_waddr == $past(r_slot, 2)))
        else $error("refill address differs from read slot");

endmodule
